FILE: rtl/slie_pkg.sv
// Shared types and codes for the straight-line integer evaluator.
// No dependencies.
package slie_pkg;
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_EXEC = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [3:0] ALU_ADD  = 4'd0;
	localparam logic [3:0] ALU_SUB  = 4'd1;
	localparam logic [3:0] ALU_MUL  = 4'd2;
	localparam logic [3:0] ALU_UDIV = 4'd3;
	localparam logic [3:0] ALU_SDIV = 4'd4;
	localparam logic [3:0] ALU_AND  = 4'd5;
	localparam logic [3:0] ALU_OR   = 4'd6;
	localparam logic [3:0] ALU_XOR  = 4'd7;
	localparam logic [3:0] ALU_SHL  = 4'd8;
	localparam logic [3:0] ALU_LSHR = 4'd9;
	localparam logic [3:0] ALU_ASHR = 4'd10;
	localparam logic [3:0] ALU_ICMP = 4'd11;

	localparam logic [3:0] CMP_EQ  = 4'd0;
	localparam logic [3:0] CMP_NE  = 4'd1;
	localparam logic [3:0] CMP_ULT = 4'd2;
	localparam logic [3:0] CMP_ULE = 4'd3;
	localparam logic [3:0] CMP_UGT = 4'd4;
	localparam logic [3:0] CMP_UGE = 4'd5;
	localparam logic [3:0] CMP_SLT = 4'd6;
	localparam logic [3:0] CMP_SLE = 4'd7;
	localparam logic [3:0] CMP_SGT = 4'd8;
	localparam logic [3:0] CMP_SGE = 4'd9;

	localparam int SHIFT_BITS = 6;

	// classified request handed from front to back
	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] load_value;
		logic [3:0]  alu_code;
		logic [3:0]  compare_kind;
		logic [6:0]  first_index;
		logic [6:0]  second_index;
		logic [6:0]  result_index;
		logic        multi;  // needs the multicycle unit
	} req_t;
endpackage

FILE: rtl/straight_line_integer_evaluator.sv
// Top level of the straight-line integer evaluator.
// Depends on slie_pkg, slie_front, slie_back.
//
// The back end reads store operands through a registered read port (one operand
// per cycle). Multiply sums four 16x64 partial products and divide produces one
// quotient bit per cycle. A two-entry queue lets new requests enter while the back
// end works or its result waits.
module straight_line_integer_evaluator import slie_pkg::*; #(
	parameter int STORE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [63:0] load_value,
	input  logic [3:0]  alu_code,
	input  logic [3:0]  compare_kind,
	input  logic signed [6:0] first_index,
	input  logic signed [6:0] second_index,
	input  logic signed [6:0] result_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value,
	output logic        store_overflow
);
	logic q_valid, q_pop;
	req_t q_head;

	slie_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready),
		.op(op), .load_value(load_value), .alu_code(alu_code),
		.compare_kind(compare_kind), .first_index(first_index),
		.second_index(second_index), .result_index(result_index),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
	);

	slie_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_head(q_head), .out_valid(out_valid), .out_ready(out_ready),
		.value(value), .store_overflow(store_overflow)
	);
endmodule

FILE: rtl/slie_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on slie_pkg.
module slie_front import slie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  op,
	input  logic [63:0] load_value,
	input  logic [3:0]  alu_code,
	input  logic [3:0]  compare_kind,
	input  logic [6:0]  first_index,
	input  logic [6:0]  second_index,
	input  logic [6:0]  result_index,
	output logic        q_valid,
	input  logic        q_pop,
	output req_t        q_head
);
	req_t       fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	req_t       cls;
	logic       push;

	always_comb begin
		cls.op = op;
		cls.load_value = load_value;
		cls.alu_code = alu_code;
		cls.compare_kind = compare_kind;
		cls.first_index = first_index;
		cls.second_index = second_index;
		cls.result_index = result_index;
		cls.multi = (op == OP_EXEC) &&
			(alu_code == ALU_MUL || alu_code == ALU_UDIV || alu_code == ALU_SDIV);
	end

	assign ready = (cnt_q != 2'd2);
	assign push = valid && ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !ready) else $error("ready while queue full");
endmodule

FILE: rtl/slie_muldiv.sv
// Multicycle 64-bit multiply (16x64 partial products) and radix-2 divider.
// Depends on slie_pkg.
module slie_muldiv import slie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [3:0]  alu_code,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] result
);
	logic        busy_q, is_mul_q, neg_q;
	logic [6:0]  step_q;
	logic [63:0] acc_q, mcand_q, mplr_q, rem_q, quo_q, dvs_q;
	logic [63:0] ma, mb, pp;
	logic [65:0] trial;
	logic [64:0] rsh;
	logic        sgn;

	always_comb begin
		sgn = (alu_code == ALU_SDIV);
		ma = (sgn && a[63]) ? (64'd0 - a) : a;
		mb = (sgn && b[63]) ? (64'd0 - b) : b;
		pp = mcand_q * {48'd0, mplr_q[15:0]};
		rsh = {rem_q, quo_q[63]};
		trial = {1'b0, rsh} - {2'b00, dvs_q};
	end

	assign done = busy_q && (is_mul_q ? (step_q == 7'd4) : (step_q == 7'd64));
	assign result = is_mul_q ? acc_q : (neg_q ? (64'd0 - quo_q) : quo_q);

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= 64'd0;
			mcand_q <= a;
			mplr_q <= b;
			rem_q <= 64'd0;
			quo_q <= ma;
			dvs_q <= mb;
			neg_q <= sgn && (a[63] != b[63]);
			is_mul_q <= (alu_code == ALU_MUL);
		end else if (busy_q && !done) begin
			if (is_mul_q) begin
				acc_q <= acc_q + pp;
				mcand_q <= {mcand_q[47:0], 16'd0};
				mplr_q <= {16'd0, mplr_q[63:16]};
			end else begin
				// restoring divide step
				if (!trial[65]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= rsh[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
		end
	end

	// hold done and the result until the next start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 7'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= 7'd0;
		end else if (busy_q && !done) begin
			step_q <= step_q + 7'd1;
		end
	end
endmodule

FILE: rtl/slie_back.sv
// Back end: store reads, ALU, append and output register.
// Depends on slie_pkg and slie_muldiv.
module slie_back import slie_pkg::*; #(
	parameter int STORE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  req_t        q_head,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value,
	output logic        store_overflow
);
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_RD1 = 3'd1, ST_RD2 = 3'd2,
		ST_EXEC = 3'd3, ST_WAIT = 3'd4;

	logic [63:0] mem [STORE_DEPTH];
	logic [63:0] rdata_q, opa_q, opb_q;
	logic [2:0]  state_q;
	logic [CW-1:0] count_q;
	req_t        cur_q;
	logic        va_q, vb_q;
	logic        out_valid_q;
	logic [63:0] value_q;
	logic        ovf_q;
	logic [AW-1:0] raddr;
	logic        ren;
	logic        fin;
	logic [63:0] res;
	logic        md_start, md_done;
	logic        md_start_q;
	logic [63:0] md_res;
	logic [5:0]  sh;
	logic        cmp, full;

	function automatic logic idx_ok(input logic [6:0] idx, input logic [CW-1:0] cnt);
		logic ok;
		ok = !idx[6] && (32'(idx[5:0]) < 32'(cnt));
		return ok;
	endfunction

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign full = (count_q == CW'(STORE_DEPTH));
	assign sh = opb_q[SHIFT_BITS-1:0];

	always_comb begin
		ren = 1'b0;
		raddr = '0;
		if (state_q == ST_RD1) begin
			ren = 1'b1;
			raddr = (cur_q.op == OP_READ) ? AW'(cur_q.result_index) :
				AW'(cur_q.first_index);
		end else if (state_q == ST_RD2 && cur_q.op == OP_EXEC) begin
			// a read waiting on the output keeps its data
			ren = 1'b1;
			raddr = AW'(cur_q.second_index);
		end
	end

	always_comb begin
		case (cur_q.compare_kind)
			CMP_EQ:  cmp = opa_q == opb_q;
			CMP_NE:  cmp = opa_q != opb_q;
			CMP_ULT: cmp = opa_q < opb_q;
			CMP_ULE: cmp = opa_q <= opb_q;
			CMP_UGT: cmp = opa_q > opb_q;
			CMP_UGE: cmp = opa_q >= opb_q;
			CMP_SLT: cmp = $signed(opa_q) < $signed(opb_q);
			CMP_SLE: cmp = $signed(opa_q) <= $signed(opb_q);
			CMP_SGT: cmp = $signed(opa_q) > $signed(opb_q);
			CMP_SGE: cmp = $signed(opa_q) >= $signed(opb_q);
			default: cmp = 1'b0;
		endcase
		case (cur_q.alu_code)
			ALU_ADD:  res = opa_q + opb_q;
			ALU_SUB:  res = opa_q - opb_q;
			ALU_AND:  res = opa_q & opb_q;
			ALU_OR:   res = opa_q | opb_q;
			ALU_XOR:  res = opa_q ^ opb_q;
			ALU_SHL:  res = opa_q << sh;
			ALU_LSHR: res = opa_q >> sh;
			ALU_ASHR: res = 64'($signed(opa_q) >>> sh);
			ALU_ICMP: res = {63'd0, cmp};
			default:  res = 64'd0;
		endcase
		if (!(va_q && vb_q)) res = 64'd0;
	end

	// second operand is still in the read register during ST_EXEC
	assign md_start = (state_q == ST_EXEC) && cur_q.multi && va_q && vb_q &&
		!(cur_q.alu_code != ALU_MUL && rdata_q == 64'd0);
	assign fin = !out_valid_q || out_ready;

	slie_muldiv u_md (
		.clk(clk), .arst_n(arst_n), .start(md_start), .alu_code(cur_q.alu_code),
		.a(opa_q), .b(rdata_q), .done(md_done), .result(md_res)
	);

	always_ff @(posedge clk) begin
		if (ren) rdata_q <= mem[raddr];
		if (q_pop) cur_q <= q_head;
		if (state_q == ST_RD2) opa_q <= rdata_q;
		if (state_q == ST_EXEC) begin
			// first valid operand leads; second fills the other slot
			if (va_q) opb_q <= rdata_q;
			else opa_q <= rdata_q;
		end
	end

	// store append
	logic        app;
	logic [63:0] app_val;
	always_ff @(posedge clk) begin
		if (app && !full) mem[count_q[AW-1:0]] <= app_val;
	end

	logic        finish;
	logic [63:0] fin_val;
	always_comb begin
		finish = 1'b0;
		fin_val = 64'd0;
		app = 1'b0;
		case (state_q)
			ST_RD1: begin
				if (cur_q.op == OP_LOAD) begin
					finish = fin; fin_val = cur_q.load_value; app = fin;
				end else if (cur_q.op != OP_EXEC && cur_q.op != OP_READ) begin
					finish = fin;
				end
			end
			ST_RD2: begin
				if (cur_q.op == OP_READ) begin
					finish = fin;
					fin_val = idx_ok(cur_q.result_index, count_q) ? rdata_q : 64'd0;
				end
			end
			ST_WAIT: begin
				if (!cur_q.multi || !md_start_q) begin
					finish = fin; fin_val = cur_q.multi ? 64'd0 : res; app = fin;
				end else if (md_done) begin
					finish = fin; fin_val = md_res; app = fin;
				end
			end
			default: ;
		endcase
	end
	assign app_val = fin_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
			value_q <= 64'd0;
			ovf_q <= 1'b0;
			va_q <= 1'b0;
			vb_q <= 1'b0;
			md_start_q <= 1'b0;
		end else begin
			out_valid_q <= finish || (out_valid_q && !out_ready);
			if (finish) begin
				value_q <= fin_val;
				ovf_q <= app && full;
				if (app && !full) count_q <= count_q + CW'(1);
				if (cur_q.op == OP_READ) count_q <= '0;
				state_q <= ST_IDLE;
			end else begin
				case (state_q)
					ST_IDLE: if (q_pop) state_q <= ST_RD1;
					ST_RD1: if (cur_q.op == OP_EXEC || cur_q.op == OP_READ)
						state_q <= ST_RD2;
					ST_RD2: begin
						va_q <= idx_ok(cur_q.first_index, count_q);
						vb_q <= idx_ok(cur_q.second_index, count_q);
						if (cur_q.op == OP_EXEC) state_q <= ST_EXEC;
					end
					ST_EXEC: begin
						md_start_q <= md_start;
						state_q <= ST_WAIT;
					end
					default: ;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign store_overflow = ovf_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STORE_DEPTH)) else $error("store count overflow");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !out_valid_q || state_q == ST_IDLE) else $error("pop while busy");
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && cur_q.op == OP_READ) |=> count_q == '0) else $error("read did not clear");
endmodule

FILE: verif/straight_line_integer_evaluator_checker.sv
// Checker for the straight-line integer evaluator: watches both channels,
// predicts each result from its own copy of the value store, and compares.
// Depends on slie_pkg.
module straight_line_integer_evaluator_checker import slie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [63:0] load_value,
	input  logic [3:0]  alu_code,
	input  logic [3:0]  compare_kind,
	input  logic [6:0]  first_index,
	input  logic [6:0]  second_index,
	input  logic [6:0]  result_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] value,
	input  logic        store_overflow,
	output int          fail_count,
	output int          pending_count,
	output int          result_count
);
	localparam int DEPTH = 64;

	typedef struct packed {
		logic [63:0] value;
		logic        overflow;
	} result_t;

	logic [63:0] shadow_store [DEPTH];
	int          shadow_count;
	result_t     expected_results [$];

	function automatic logic fetch_operand(input logic [6:0] idx, output logic [63:0] v);
		int i;
		i = $signed(idx);
		v = '0;
		if (i < 0 || i >= shadow_count) return 1'b0;
		v = shadow_store[i];
		return 1'b1;
	endfunction

	function automatic logic [63:0] alu_result(input logic [3:0] code, input logic [3:0] kind,
			input logic [63:0] a, input logic [63:0] b);
		logic [5:0] sh;
		logic signed [63:0] sa, sb;
		logic [63:0] ma, mb, q;
		sh = b[SHIFT_BITS-1:0];
		sa = a;
		sb = b;
		case (code)
			ALU_ADD:  return a + b;
			ALU_SUB:  return a - b;
			ALU_MUL:  return a * b;
			ALU_UDIV: return (b == 0) ? 64'd0 : a / b;
			ALU_SDIV: begin
				if (b == 0) return 64'd0;
				ma = a[63] ? -a : a;
				mb = b[63] ? -b : b;
				q = ma / mb;
				return (a[63] != b[63]) ? -q : q;
			end
			ALU_AND:  return a & b;
			ALU_OR:   return a | b;
			ALU_XOR:  return a ^ b;
			ALU_SHL:  return a << sh;
			ALU_LSHR: return a >> sh;
			ALU_ASHR: return sa >>> sh;
			ALU_ICMP: begin
				case (kind)
					CMP_EQ:  return {63'd0, a == b};
					CMP_NE:  return {63'd0, a != b};
					CMP_ULT: return {63'd0, a < b};
					CMP_ULE: return {63'd0, a <= b};
					CMP_UGT: return {63'd0, a > b};
					CMP_UGE: return {63'd0, a >= b};
					CMP_SLT: return {63'd0, sa < sb};
					CMP_SLE: return {63'd0, sa <= sb};
					CMP_SGT: return {63'd0, sa > sb};
					CMP_SGE: return {63'd0, sa >= sb};
					default: return 64'd0;
				endcase
			end
			default: return 64'd0;
		endcase
	endfunction

	function automatic logic append_value(input logic [63:0] v);
		if (shadow_count >= DEPTH) return 1'b1;
		shadow_store[shadow_count] = v;
		shadow_count++;
		return 1'b0;
	endfunction

	task automatic predict_request();
		result_t r;
		logic [63:0] a, b;
		logic ha, hb;
		r = '0;
		case (op)
			OP_LOAD: begin
				r.value = load_value;
				r.overflow = append_value(load_value);
			end
			OP_EXEC: begin
				ha = fetch_operand(first_index, a);
				hb = fetch_operand(second_index, b);
				// skip invalid operands: the valid one moves to the first slot
				if (!ha && hb) begin
					a = b;
					ha = 1'b1;
					hb = 1'b0;
				end
				r.value = (ha && hb) ? alu_result(alu_code, compare_kind, a, b) : 64'd0;
				r.overflow = append_value(r.value);
			end
			OP_READ: begin
				if (!fetch_operand(result_index, r.value)) r.value = '0;
				shadow_count = 0;
			end
			default: ;
		endcase
		expected_results = {expected_results, r};
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			shadow_count = 0;
			expected_results.delete();
			fail_count <= 0;
			result_count <= 0;
			pending_count <= 0;
		end else begin
			if (in_valid && in_ready) predict_request();
			if (out_valid && out_ready) begin
				result_count <= result_count + 1;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result value=%h ovf=%b", $time, value,
						store_overflow);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_results.pop_front();
					if (e.value !== value) begin
						$display("%0t: value expected %h actual %h", $time, e.value, value);
						fail_count <= fail_count + 1;
					end else if (e.overflow !== store_overflow) begin
						$display("%0t: store_overflow expected %b actual %b", $time,
							e.overflow, store_overflow);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= expected_results.size();
		end
	end
endmodule

FILE: verif/straight_line_integer_evaluator_test.sv
// Top of the straight-line integer evaluator testbench: clock, reset, request
// stimulus with random gaps and stalls, and the verdict.
// Depends on slie_pkg, straight_line_integer_evaluator and its checker.
module straight_line_integer_evaluator_test;
	import slie_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_VECTORS = 90;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = OP_LOAD;
	logic [63:0] load_value = '0;
	logic [3:0]  alu_code = ALU_ADD;
	logic [3:0]  compare_kind = CMP_EQ;
	logic [6:0]  first_index = '0;
	logic [6:0]  second_index = '0;
	logic [6:0]  result_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] value;
	logic        store_overflow;
	int          fail_count, pending_count, result_count;
	int          request_count = 0;
	int          idle_cycles = 0;
	logic        stimulus_done = 1'b0;

	always #5 clk = ~clk;

	straight_line_integer_evaluator dut (.*);
	straight_line_integer_evaluator_checker checker_inst (.*);

	// watchdog: count cycles in which nothing is accepted
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("straight_line_integer_evaluator test failed");
			$finish;
		end
	end

	// result side stall: hold ready low a random number of cycles per result
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			repeat (stall) @(posedge clk);
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			out_ready <= 1'b0;
		end
	end

	task automatic send_request(input logic [1:0] o, input logic [63:0] lv,
			input logic [3:0] code, input logic [3:0] kind, input int a, input int b,
			input int r);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		load_value <= lv;
		alu_code <= code;
		compare_kind <= kind;
		first_index <= a[6:0];
		second_index <= b[6:0];
		result_index <= r[6:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		request_count++;
	endtask

	function automatic logic [63:0] random_word();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return 64'h8000_0000_0000_0000;
			2: return '1;
			3: return 64'h7fff_ffff_ffff_ffff;
			4: return {60'd0, 4'($urandom)};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic int random_index(input int count);
		case ($urandom_range(0, 9))
			0: return -1;
			1: return $urandom_range(0, 63) - 64;
			2: return $urandom_range(0, 63);
			default: return (count > 0) ? $urandom_range(0, count - 1) : -1;
		endcase
	endfunction

	task automatic load_word(input logic [63:0] v, inout int count);
		send_request(OP_LOAD, v, 4'($urandom), 4'($urandom), $urandom_range(0, 127) - 64,
			$urandom_range(0, 127) - 64, $urandom_range(0, 127) - 64);
		if (count < 64) count++;
	endtask

	task automatic exec_op(input logic [3:0] code, input logic [3:0] kind, input int a,
			input int b, inout int count);
		send_request(OP_EXEC, {$urandom, $urandom}, code, kind, a, b,
			$urandom_range(0, 127) - 64);
		if (count < 64) count++;
	endtask

	initial begin
		int count, n;
		count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, division corners, every request op and predicate
		load_word(64'h8000_0000_0000_0000, count);
		load_word('1, count);
		load_word(64'd0, count);
		load_word(64'd70, count);
		exec_op(ALU_SDIV, CMP_EQ, 0, 1, count);
		exec_op(ALU_UDIV, CMP_EQ, 3, 2, count);
		exec_op(ALU_SDIV, CMP_EQ, 3, 2, count);
		exec_op(ALU_ASHR, CMP_EQ, 0, 3, count);
		exec_op(ALU_ADD, CMP_EQ, -1, 1, count);
		exec_op(ALU_SUB, CMP_EQ, 40, -1, count);
		for (int k = 0; k < 10; k++) exec_op(ALU_ICMP, 4'(k), 0, 1, count);
		exec_op(ALU_ICMP, 4'd15, 0, 1, count);
		exec_op(4'd15, CMP_EQ, 0, 1, count);
		send_request(OP_READ, '0, ALU_ADD, CMP_EQ, 0, 0, -64);
		send_request(2'd3, '1, ALU_ADD, CMP_EQ, 0, 0, 0);
		count = 0;

		// random vectors: loads, then a program, now and then an unknown op, then one read
		for (int v = 0; v < RANDOM_VECTORS; v++) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) load_word(random_word(), count);
			// fill the store now and then to hit the overflow path
			n = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(1, 16);
			for (int i = 0; i < n; i++)
				exec_op(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					random_index(count), random_index(count), count);
			if ($urandom_range(0, 19) == 0)
				send_request(2'd3, random_word(), 4'($urandom), 4'($urandom), 0, 0, 0);
			send_request(OP_READ, random_word(), 4'($urandom), 4'($urandom), 0, 0,
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) - 64
					: random_index(count));
			count = 0;
		end
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	initial begin
		wait (stimulus_done);
		while (pending_count != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d requests and %0d results over loads, all ALU ops,",
			request_count, result_count);
		$display("predicates, operand skipping, store overflow and out-of-range reads");
		if (fail_count == 0) $display("straight_line_integer_evaluator test passed");
		else $display("straight_line_integer_evaluator test failed");
		$finish;
	end
endmodule
